// ===== sv/deq_pkg.sv =====
// deq_pkg: shared types, constants and helpers for the double-ended queue.
// Depends on nothing; used by every module of the block by scoped names.
package deq_pkg;

    // Ring store geometry
    localparam int DEPTH   = 16;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = PTR_W + 1;

    // Field widths fixed by the interface
    localparam int KIND_W  = 3;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;
    localparam int FILL_W  = 5;

    // Command queue between front and back
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // Request kind codes as seen on the input
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PEEK_FRONT = 3'd4;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    // Decoded operation passed from front to back
    typedef enum logic [2:0] {
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_PEEK_FRONT,
        OP_NOP
    } t_op;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [DATA_W-1:0] data_in;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] data_out;
        logic [STAT_W-1:0]        status;
        logic [FILL_W-1:0]        fill_count;
        logic                     is_empty;
    } t_out_item;

    typedef struct packed {
        t_op                      op;
        logic signed [DATA_W-1:0] data;
    } t_cmd;

    // Reduce a sum below 2*DEPTH to a ring position
    function automatic logic [PTR_W-1:0] ring_wrap(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] r;
        r = (s >= SUM_W'(DEPTH)) ? s - SUM_W'(DEPTH) : s;
        return r[PTR_W-1:0];
    endfunction

endpackage

// ===== sv/deq_front.sv =====
// deq_front: takes input transfers, decodes the kind and holds commands in
// a short queue for the back end. Depends on deq_pkg.
module deq_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  deq_pkg::t_in_item i_in,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output deq_pkg::t_cmd     o_cmd
);

    deq_pkg::t_cmd                     r_q [deq_pkg::CMDQ_DEPTH];
    logic [deq_pkg::CMDQ_PTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [deq_pkg::CMDQ_PTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [deq_pkg::CMDQ_CNT_W-1:0]    r_cnt, n_cnt;
    deq_pkg::t_cmd                     w_dec;
    logic                              w_push, w_pop;

    // Kind decode; undefined kinds become a no-op
    always_comb begin
        w_dec.data = i_in.data_in;
        unique case (i_in.kind)
            deq_pkg::KIND_PUSH_FRONT: w_dec.op = deq_pkg::OP_PUSH_FRONT;
            deq_pkg::KIND_PUSH_BACK:  w_dec.op = deq_pkg::OP_PUSH_BACK;
            deq_pkg::KIND_POP_FRONT:  w_dec.op = deq_pkg::OP_POP_FRONT;
            deq_pkg::KIND_POP_BACK:   w_dec.op = deq_pkg::OP_POP_BACK;
            deq_pkg::KIND_PEEK_FRONT: w_dec.op = deq_pkg::OP_PEEK_FRONT;
            default:                  w_dec.op = deq_pkg::OP_NOP;
        endcase
    end

    assign o_in_ready  = (r_cnt != deq_pkg::CMDQ_CNT_W'(deq_pkg::CMDQ_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign w_push      = i_in_valid && o_in_ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == deq_pkg::CMDQ_PTR_W'(deq_pkg::CMDQ_DEPTH - 1))
                     ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == deq_pkg::CMDQ_PTR_W'(deq_pkg::CMDQ_DEPTH - 1))
                     ? '0 : r_rd_ptr + 1'b1;
        end
        n_cnt = r_cnt + deq_pkg::CMDQ_CNT_W'(w_push) - deq_pkg::CMDQ_CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // Payload slots, no reset
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_dec;
        end
    end

endmodule

// ===== sv/deq_back.sv =====
// deq_back: carries out queued commands on the ring store and registers the
// result. Depends on deq_pkg.
module deq_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  deq_pkg::t_cmd      i_cmd,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output deq_pkg::t_out_item o_out
);

    logic signed [deq_pkg::DATA_W-1:0] r_mem [deq_pkg::DEPTH];
    logic [deq_pkg::PTR_W-1:0]         r_front, n_front;
    logic [deq_pkg::CNT_W-1:0]         r_count, n_count;
    logic                              r_out_valid;
    deq_pkg::t_out_item                r_out;
    logic [deq_pkg::STAT_W-1:0]        n_status;

    logic                              w_take, w_full, w_empty, w_wr_en, w_rd_en;
    logic [deq_pkg::PTR_W-1:0]         w_front_dec, w_front_inc;
    logic [deq_pkg::PTR_W-1:0]         w_tail, w_last, w_wr_idx, w_rd_idx;

    assign o_cmd_ready = !r_out_valid || i_out_ready;
    assign w_take      = i_cmd_valid && o_cmd_ready;
    assign w_full      = (r_count == deq_pkg::CNT_W'(deq_pkg::DEPTH));
    assign w_empty     = (r_count == '0);

    assign w_front_dec = (r_front == '0) ? deq_pkg::PTR_W'(deq_pkg::DEPTH - 1)
                                         : r_front - 1'b1;
    assign w_front_inc = (r_front == deq_pkg::PTR_W'(deq_pkg::DEPTH - 1)) ? '0
                                         : r_front + 1'b1;
    // Slot after the last entry, and the last entry itself
    assign w_tail = deq_pkg::ring_wrap(deq_pkg::SUM_W'(r_front)
                                       + deq_pkg::SUM_W'(r_count));
    assign w_last = deq_pkg::ring_wrap(deq_pkg::SUM_W'(r_front)
                                       + deq_pkg::SUM_W'(r_count) - 1'b1);

    always_comb begin
        n_front  = r_front;
        n_count  = r_count;
        w_wr_en  = 1'b0;
        w_wr_idx = w_tail;
        w_rd_en  = 1'b0;
        w_rd_idx = r_front;
        n_status = deq_pkg::STAT_OK;
        unique case (i_cmd.op)
            deq_pkg::OP_PUSH_FRONT: begin
                if (w_full) begin
                    n_status = deq_pkg::STAT_FULL;
                end else begin
                    n_front  = w_front_dec;
                    w_wr_idx = w_front_dec;
                    w_wr_en  = 1'b1;
                    n_count  = r_count + 1'b1;
                end
            end
            deq_pkg::OP_PUSH_BACK: begin
                if (w_full) begin
                    n_status = deq_pkg::STAT_FULL;
                end else begin
                    w_wr_en = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            deq_pkg::OP_POP_FRONT, deq_pkg::OP_PEEK_FRONT: begin
                if (w_empty) begin
                    n_status = deq_pkg::STAT_EMPTY;
                end else begin
                    w_rd_en = 1'b1;
                    if (i_cmd.op == deq_pkg::OP_POP_FRONT) begin
                        n_front = w_front_inc;
                        n_count = r_count - 1'b1;
                    end
                end
            end
            deq_pkg::OP_POP_BACK: begin
                if (w_empty) begin
                    n_status = deq_pkg::STAT_EMPTY;
                end else begin
                    w_rd_en  = 1'b1;
                    w_rd_idx = w_last;
                    n_count  = r_count - 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_front <= n_front;
                r_count <= n_count;
            end
            if (o_cmd_ready) begin
                r_out_valid <= i_cmd_valid;
            end
        end
    end

    // Ring store and result payload, no reset; the read lands in the result register
    always_ff @(posedge i_clk) begin
        if (w_take && w_wr_en) begin
            r_mem[w_wr_idx] <= i_cmd.data;
        end
        if (w_take) begin
            r_out.data_out   <= w_rd_en ? r_mem[w_rd_idx] : '0;
            r_out.status     <= n_status;
            r_out.fill_count <= deq_pkg::FILL_W'(n_count);
            r_out.is_empty   <= (n_count == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== sv/double_ended_queue_top.sv =====
// double_ended_queue_top: top level of the bounded double-ended queue.
// Depends on deq_pkg, deq_front and deq_back.
//
// Bounded deque of signed 32-bit words in a 16-entry ring store. Each input
// transfer carries a kind (push front, push back, pop front, pop back, peek
// front) and a value; each one yields exactly one output transfer with the
// popped or peeked value, a status (ok, empty, full), the fill count after
// the operation and an empty flag. Pops and peeks on an empty deque give 0
// with status empty; a push into a full deque is dropped with status full;
// unused kind codes do nothing and report ok. The front end decodes each
// transfer into a two-entry command queue; the back end executes one
// command per cycle while its output is not stalled, against the ring store
// (front index plus count), and holds the result in an output register.
// Sustained rate is one item per clock when not stalled, limited by the
// single read/modify step of the back end; each input reaches its result
// through the command queue slot and then the output register. Either side
// may stall independently: the command queue and output register decouple
// them. Nothing needs clearing after reset; unwritten ring slots are never read.
module double_ended_queue_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  deq_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output deq_pkg::t_out_item o_out
);

    // Front-to-back command channel
    logic          w_cmd_valid;
    logic          w_cmd_ready;
    deq_pkg::t_cmd w_cmd;

    deq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd       (w_cmd)
    );

    deq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

// ===== sv/deq_checker.sv =====
// deq_checker: port-level checks on the double-ended queue, bound to the top.
// Depends on deq_pkg and double_ended_queue_top.
module deq_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input deq_pkg::t_in_item  i_in,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input deq_pkg::t_out_item o_out
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // Empty flag agrees with fill count
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.is_empty == (o_out.fill_count == '0)))
        else $error("empty flag disagrees with fill count");

    // Waiting request holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in))
        else $error("request changed while waiting");

    // Empty status means zero data on an empty deque
    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status == deq_pkg::STAT_EMPTY)
        |-> (o_out.data_out == '0) && o_out.is_empty)
        else $error("empty status with data or entries");

    // Full status only when the ring is full
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status == deq_pkg::STAT_FULL)
        |-> (o_out.fill_count == deq_pkg::FILL_W'(deq_pkg::DEPTH))
            && (o_out.data_out == '0))
        else $error("full status on a ring with room");

endmodule

bind double_ended_queue_top deq_checker u_deq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
